FILE: hw/rtl/lll_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and token codes for the IR line lexer.
package lll_pkg;

    localparam int MAX_LINE_DEF = 1024;

    localparam int TYPE_W     = 5;
    localparam int SPOS_W     = 10;
    localparam int LEN_W      = 11;
    localparam int RES_PER_CH = 3;
    localparam int RESQ_DEPTH = 8;
    localparam int RESQ_CW    = $clog2(RESQ_DEPTH) + 1;

    typedef enum logic [3:0] {
        M_IDLE,
        M_COMMENT,
        M_STR,
        M_STR_ESC,
        M_SIGIL,
        M_MINUS,
        M_INT,
        M_DOT,
        M_FRAC,
        M_WORD
    } t_mode;

    localparam logic [TYPE_W-1:0] TK_COMMENT  = 5'd0;
    localparam logic [TYPE_W-1:0] TK_STRING   = 5'd1;
    localparam logic [TYPE_W-1:0] TK_PERCENT  = 5'd2;
    localparam logic [TYPE_W-1:0] TK_DOLLAR   = 5'd3;
    localparam logic [TYPE_W-1:0] TK_LABELDEF = 5'd4;
    localparam logic [TYPE_W-1:0] TK_LABELREF = 5'd5;
    localparam logic [TYPE_W-1:0] TK_ARROW    = 5'd6;
    localparam logic [TYPE_W-1:0] TK_NUMBER   = 5'd7;
    localparam logic [TYPE_W-1:0] TK_WORD     = 5'd8;
    localparam logic [TYPE_W-1:0] TK_EQ       = 5'd9;
    localparam logic [TYPE_W-1:0] TK_LPAREN   = 5'd10;
    localparam logic [TYPE_W-1:0] TK_RPAREN   = 5'd11;
    localparam logic [TYPE_W-1:0] TK_LBRACK   = 5'd12;
    localparam logic [TYPE_W-1:0] TK_RBRACK   = 5'd13;
    localparam logic [TYPE_W-1:0] TK_LT       = 5'd14;
    localparam logic [TYPE_W-1:0] TK_GT       = 5'd15;
    localparam logic [TYPE_W-1:0] TK_COMMA    = 5'd16;
    localparam logic [TYPE_W-1:0] TK_COLON    = 5'd17;
    localparam logic [TYPE_W-1:0] TK_UNKNOWN  = 5'd18;

    localparam logic [1:0] SK_PERCENT = 2'd0;
    localparam logic [1:0] SK_DOLLAR  = 2'd1;
    localparam logic [1:0] SK_AT      = 2'd2;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    typedef struct packed {
        logic [TYPE_W-1:0] token_type;
        logic [SPOS_W-1:0] start_pos;
        logic [LEN_W-1:0]  token_len;
        logic              last_in_run;
    } t_res;

    typedef struct packed {
        logic [1:0]                  cnt;
        t_res [RES_PER_CH-1:0]       res;
    } t_push;

endpackage

FILE: hw/rtl/lll_step.sv
`timescale 1ns / 1ps
// Lexer state registers and the combinational step that yields up to three tokens per character.
module lll_step #(
    parameter int MAX_LINE = lll_pkg::MAX_LINE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [7:0]    i_ch,
    input  logic          i_end,
    output lll_pkg::t_push o_push
);
    import lll_pkg::*;

    localparam int PW = ($clog2(MAX_LINE) > SPOS_W) ? $clog2(MAX_LINE) : SPOS_W;
    localparam logic [PW:0] LAST_POS = (PW + 1)'(MAX_LINE - 1);
    localparam logic [PW:0] MAX_LEN  = (PW + 1)'(MAX_LINE);
    localparam int NCAND = 5;

    t_mode          r_mode, n_mode;
    logic [PW-1:0]  r_tok_start, n_tok_start;
    logic [PW-1:0]  r_tok_end, n_tok_end;
    logic [PW-1:0]  r_char_pos, n_char_pos;
    logic [PW-1:0]  r_prev_pos, n_prev_pos;
    logic [1:0]     r_sigil, n_sigil;

    logic [PW-1:0]  p;
    logic           is_dig, is_alp, is_wrd, is_spc;
    logic           do_begin;
    t_res           cand [NCAND];
    logic [NCAND-1:0] cand_v;
    t_res [RES_PER_CH-1:0] res;
    logic [1:0]     cnt;

    function automatic t_res mk_res(logic [TYPE_W-1:0] tt, logic [PW-1:0] s, logic [PW-1:0] e);
        logic [PW:0] len;
        t_res        r;
        len = (e >= s) ? ({1'b0, e} - {1'b0, s} + (PW + 1)'(1)) : (PW + 1)'(1);
        if (len > MAX_LEN) begin
            len = MAX_LEN;
        end
        r.token_type  = tt;
        r.start_pos   = s[SPOS_W-1:0];
        r.token_len   = len[LEN_W-1:0];
        r.last_in_run = 1'b0;
        return r;
    endfunction

    function automatic logic [TYPE_W-1:0] sigil_tt(logic [1:0] sk);
        logic [TYPE_W-1:0] t;
        case (sk)
            SK_PERCENT: t = TK_PERCENT;
            SK_DOLLAR:  t = TK_DOLLAR;
            default:    t = TK_LABELREF;
        endcase
        return t;
    endfunction

    assign p = r_char_pos;

    always_comb begin
        is_dig = i_ch inside {[8'h30:8'h39]};
        is_alp = i_ch inside {[8'h61:8'h7A], [8'h41:8'h5A]};
        is_wrd = is_dig || is_alp || (i_ch == CH_USCORE);
        is_spc = i_ch inside {8'h20, [8'h09:8'h0D]};
    end

    always_comb begin
        n_mode      = r_mode;
        n_tok_start = r_tok_start;
        n_tok_end   = r_tok_end;
        n_sigil     = r_sigil;
        n_char_pos  = r_char_pos;
        n_prev_pos  = r_prev_pos;
        do_begin    = 1'b0;
        cand_v      = '0;
        for (int i = 0; i < NCAND; i++) begin
            cand[i] = '0;
        end

        case (r_mode)
            M_COMMENT: begin
                n_tok_end = p;
            end
            M_STR: begin
                n_tok_end = p;
                if (i_ch == CH_BSLASH && !i_end) begin
                    n_mode = M_STR_ESC;
                end else if (i_ch == CH_QUOTE) begin
                    cand[0]   = mk_res(TK_STRING, r_tok_start, p);
                    cand_v[0] = 1'b1;
                    n_mode    = M_IDLE;
                end
            end
            M_STR_ESC: begin
                n_tok_end = p;
                n_mode    = M_STR;
            end
            M_SIGIL: begin
                if (is_wrd) begin
                    n_tok_end = p;
                end else if (r_sigil == SK_AT && i_ch == CH_COLON) begin
                    cand[0]   = mk_res(TK_LABELDEF, r_tok_start, p);
                    cand_v[0] = 1'b1;
                    n_mode    = M_IDLE;
                end else begin
                    cand[0]   = mk_res(sigil_tt(r_sigil), r_tok_start, r_tok_end);
                    cand_v[0] = 1'b1;
                    do_begin  = 1'b1;
                end
            end
            M_MINUS: begin
                if (i_ch == CH_GT) begin
                    cand[0]   = mk_res(TK_ARROW, r_tok_start, p);
                    cand_v[0] = 1'b1;
                    n_mode    = M_IDLE;
                end else if (is_dig) begin
                    n_tok_end = p;
                    n_mode    = M_INT;
                end else begin
                    cand[0]   = mk_res(TK_UNKNOWN, r_tok_start, r_tok_start);
                    cand_v[0] = 1'b1;
                    do_begin  = 1'b1;
                end
            end
            M_INT: begin
                if (is_dig) begin
                    n_tok_end = p;
                end else if (i_ch == CH_DOT && !i_end) begin
                    n_mode = M_DOT;
                end else begin
                    cand[0]   = mk_res(TK_NUMBER, r_tok_start, r_tok_end);
                    cand_v[0] = 1'b1;
                    do_begin  = 1'b1;
                end
            end
            M_DOT: begin
                if (is_dig) begin
                    n_tok_end = p;
                    n_mode    = M_FRAC;
                end else begin
                    cand[0]   = mk_res(TK_NUMBER, r_tok_start, r_tok_end);
                    cand[1]   = mk_res(TK_UNKNOWN, r_prev_pos, r_prev_pos);
                    cand_v[0] = 1'b1;
                    cand_v[1] = 1'b1;
                    do_begin  = 1'b1;
                end
            end
            M_FRAC: begin
                if (is_dig) begin
                    n_tok_end = p;
                end else begin
                    cand[0]   = mk_res(TK_NUMBER, r_tok_start, r_tok_end);
                    cand_v[0] = 1'b1;
                    do_begin  = 1'b1;
                end
            end
            M_WORD: begin
                if (is_wrd) begin
                    n_tok_end = p;
                end else begin
                    cand[0]   = mk_res(TK_WORD, r_tok_start, r_tok_end);
                    cand_v[0] = 1'b1;
                    do_begin  = 1'b1;
                end
            end
            default: begin
                do_begin = 1'b1;
            end
        endcase

        if (do_begin) begin
            n_mode      = M_IDLE;
            n_tok_start = p;
            n_tok_end   = p;
            if (!is_spc) begin
                if (i_ch == CH_HASH) begin
                    n_mode = M_COMMENT;
                end else if (i_ch == CH_QUOTE) begin
                    n_mode = M_STR;
                end else if (i_ch == CH_PCT) begin
                    n_sigil = SK_PERCENT;
                    n_mode  = M_SIGIL;
                end else if (i_ch == CH_DOLLAR) begin
                    n_sigil = SK_DOLLAR;
                    n_mode  = M_SIGIL;
                end else if (i_ch == CH_AT) begin
                    n_sigil = SK_AT;
                    n_mode  = M_SIGIL;
                end else if (i_ch == CH_MINUS && !i_end) begin
                    n_mode = M_MINUS;
                end else if (is_dig) begin
                    n_mode = M_INT;
                end else if (is_alp || i_ch == CH_USCORE) begin
                    n_mode = M_WORD;
                end else begin
                    cand_v[2] = 1'b1;
                    case (i_ch)
                        CH_EQ:     cand[2] = mk_res(TK_EQ, p, p);
                        CH_LPAREN: cand[2] = mk_res(TK_LPAREN, p, p);
                        CH_RPAREN: cand[2] = mk_res(TK_RPAREN, p, p);
                        CH_LBRACK: cand[2] = mk_res(TK_LBRACK, p, p);
                        CH_RBRACK: cand[2] = mk_res(TK_RBRACK, p, p);
                        CH_LT:     cand[2] = mk_res(TK_LT, p, p);
                        CH_GT:     cand[2] = mk_res(TK_GT, p, p);
                        CH_COMMA:  cand[2] = mk_res(TK_COMMA, p, p);
                        CH_COLON:  cand[2] = mk_res(TK_COLON, p, p);
                        default:   cand[2] = mk_res(TK_UNKNOWN, p, p);
                    endcase
                end
            end
        end

        if (i_end) begin
            case (n_mode)
                M_COMMENT: begin
                    cand[3]   = mk_res(TK_COMMENT, n_tok_start, n_tok_end);
                    cand_v[3] = 1'b1;
                end
                M_STR, M_STR_ESC: begin
                    cand[3]   = mk_res(TK_STRING, n_tok_start, n_tok_end);
                    cand_v[3] = 1'b1;
                end
                M_SIGIL: begin
                    cand[3]   = mk_res(sigil_tt(n_sigil), n_tok_start, n_tok_end);
                    cand_v[3] = 1'b1;
                end
                M_MINUS: begin
                    cand[3]   = mk_res(TK_UNKNOWN, n_tok_start, n_tok_start);
                    cand_v[3] = 1'b1;
                end
                M_INT, M_FRAC: begin
                    cand[3]   = mk_res(TK_NUMBER, n_tok_start, n_tok_end);
                    cand_v[3] = 1'b1;
                end
                M_DOT: begin
                    cand[3]   = mk_res(TK_NUMBER, n_tok_start, n_tok_end);
                    cand[4]   = mk_res(TK_UNKNOWN, r_prev_pos, r_prev_pos);
                    cand_v[3] = 1'b1;
                    cand_v[4] = 1'b1;
                end
                M_WORD: begin
                    cand[3]   = mk_res(TK_WORD, n_tok_start, n_tok_end);
                    cand_v[3] = 1'b1;
                end
                default: begin
                end
            endcase
            n_mode      = M_IDLE;
            n_tok_start = '0;
            n_tok_end   = '0;
            n_prev_pos  = '0;
            n_char_pos  = '0;
        end else begin
            n_prev_pos = p;
            n_char_pos = ({1'b0, p} < LAST_POS) ? p + PW'(1) : LAST_POS[PW-1:0];
        end
    end

    always_comb begin
        cnt = '0;
        res = '0;
        for (int i = 0; i < NCAND; i++) begin
            if (cand_v[i] && cnt != 2'd3) begin
                res[cnt] = cand[i];
                cnt      = cnt + 2'd1;
            end
        end
        if (cnt != 2'd0) begin
            res[cnt - 2'd1].last_in_run = 1'b1;
        end
    end

    assign o_push.cnt = i_go ? cnt : 2'd0;
    assign o_push.res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_IDLE;
            r_tok_start <= '0;
            r_tok_end   <= '0;
            r_char_pos  <= '0;
            r_prev_pos  <= '0;
            r_sigil     <= SK_PERCENT;
        end else if (i_go) begin
            r_mode      <= n_mode;
            r_tok_start <= n_tok_start;
            r_tok_end   <= n_tok_end;
            r_char_pos  <= n_char_pos;
            r_prev_pos  <= n_prev_pos;
            r_sigil     <= n_sigil;
        end
    end

endmodule

FILE: hw/rtl/lll_resq.sv
`timescale 1ns / 1ps
// Result queue: takes up to three tokens per cycle, hands out one per cycle while i_pop is high.
module lll_resq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lll_pkg::t_push               i_push,
    input  logic                         i_pop,
    output logic                         o_valid,
    output lll_pkg::t_res                o_head,
    output logic [lll_pkg::RESQ_CW-1:0]  o_count
);
    import lll_pkg::*;

    localparam int AW = $clog2(RESQ_DEPTH);

    t_res              r_mem [RESQ_DEPTH];
    logic [AW-1:0]     r_wr, n_wr;
    logic [AW-1:0]     r_rd, n_rd;
    logic [RESQ_CW-1:0] r_count, n_count;
    logic              pop_ok;

    assign pop_ok  = i_pop && (r_count != '0);
    assign n_wr    = r_wr + AW'(i_push.cnt);
    assign n_rd    = r_rd + AW'(pop_ok);
    assign n_count = r_count + RESQ_CW'(i_push.cnt) - RESQ_CW'(pop_ok);

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < RES_PER_CH; i++) begin
            if (2'(i) < i_push.cnt) begin
                r_mem[r_wr + AW'(i)] <= i_push.res[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

FILE: hw/rtl/ir_line_lexer_core.sv
`timescale 1ns / 1ps
// Top level of the IR line lexer: input register, lexer step and result queue.
//
//  channel | dir | tdata                                           | tlast
//  s       | in  | [7:0] ch                                        | line_end
//  m       | out | [4:0] token_type [14:5] start_pos [25:15] len   | last_in_run
//
// One character per cycle enters the input register while s is ready, and is lexed from there once the queue has room.
// A token reaches m after its closing character has passed the input register and been written into the result queue.
// The m side drains one token per cycle while i_m_tready is high, so characters that close 2-3 tokens slow s.
// s stalls only while the 8-entry result queue lacks room for three tokens.
// Reset (synchronous, active low) returns the lexer to idle at position zero.
module ir_line_lexer_core #(
    parameter int MAX_LINE = lll_pkg::MAX_LINE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] ch
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [4:0] token_type, [14:5] start_pos, [25:15] token_len
    output logic        o_m_tlast
);
    import lll_pkg::*;

    logic               r_in_vld;
    logic [7:0]         r_in_ch;
    logic               r_in_end;
    logic               advance;
    t_push              push;
    t_res               head;
    logic [RESQ_CW-1:0] q_count;

    assign advance    = r_in_vld && (q_count <= RESQ_CW'(RESQ_DEPTH - RES_PER_CH));
    assign o_s_tready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_ch  <= i_s_tdata;
            r_in_end <= i_s_tlast;
        end
    end

    lll_step #(
        .MAX_LINE (MAX_LINE)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (advance),
        .i_ch    (r_in_ch),
        .i_end   (r_in_end),
        .o_push  (push)
    );

    lll_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_head  (head),
        .o_count (q_count)
    );

    assign o_m_tdata = {6'b0, head.token_len, head.start_pos, head.token_type};
    assign o_m_tlast = head.last_in_run;

endmodule

FILE: hw/rtl/lll_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the IR line lexer and its bind to the top level.
module lll_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic        o_m_tlast
);

    a_m_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("m transfer changed while stalled");

    a_type_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[4:0] <= 5'd18) && (o_m_tdata[31:26] == 6'd0))
        else $error("token type out of range or padding set");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[25:15] != 11'd0)
        else $error("zero token length");

    a_rise_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready, 2))
        else $error("token appeared without a character transfer two cycles before");

endmodule

bind ir_line_lexer_core lll_chk u_lll_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
